// File: rtl/core/ufp_pkg.sv
// ----------------------------------------------------------------------------
// UBX frame parser package
// Shared constants and event codes for the UBX frame parser core and checker.
// ----------------------------------------------------------------------------
package ufp_pkg;

    localparam logic [15:0] SYNC_WORD       = 16'hB562;
    localparam logic [15:0] HEADER_BYTES    = 16'd4;
    localparam logic [15:0] CHECK_BYTES     = 16'd2;
    localparam logic [15:0] CAPACITY_RESET  = 16'd512;

    localparam int          EVENT_W         = 3;

    typedef enum logic [EVENT_W-1:0] {
        EV_HUNT     = 3'd0,
        EV_SYNC     = 3'd1,
        EV_HEADER   = 3'd2,
        EV_PAYLOAD  = 3'd3,
        EV_CHECK_A  = 3'd4,
        EV_GOOD     = 3'd5,
        EV_BAD      = 3'd6,
        EV_TOO_LONG = 3'd7
    } event_t;

endpackage

// File: rtl/core/ubx_frame_parser_core.sv
// ----------------------------------------------------------------------------
// UBX frame parser core
// Hunts for the UBX sync word, checks frame length against a capacity and
// verifies the Fletcher-8 checksum, tagging every byte with position and event.
// ----------------------------------------------------------------------------
// Each accepted byte is registered and its result is shown in the next cycle.
// Throughput: 1 byte per cycle while the master side is ready; the single result
// register is refilled in the same cycle that its contents are taken.
// Reset: parser returns to sync search, capacity to 512, no result pending.
module ubx_frame_parser_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // frame_capacity

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_out, [23:8] position
    output logic [2:0]  m_axis_tuser,   // [2:0] event_res
    output logic        m_axis_tlast    // frame_end
);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [15:0]                  capacity_reg;
    logic [15:0]                  sync_shift_reg, sync_shift_next;
    logic [15:0]                  byte_count_reg, byte_count_next;
    logic [15:0]                  expected_total_reg, expected_total_next;
    logic [7:0]                   length_low_reg, length_low_next;
    logic [7:0]                   sum_a_reg, sum_a_next;
    logic [7:0]                   sum_b_reg, sum_b_next;
    logic [7:0]                   check_a_reg, check_a_next;

    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic [15:0]                  out_pos_reg, pos_next;
    ufp_pkg::event_t              out_event_reg, event_next;
    logic                         out_last_reg, last_next;

    logic                         accept;
    logic [7:0]                   rx;
    logic [7:0]                   add_a;
    logic [16:0]                  total;
    logic [16:0]                  pos_plus_check;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    assign add_a          = sum_a_reg + rx;
    assign total          = {1'b0, rx, length_low_reg}
                          + {1'b0, ufp_pkg::HEADER_BYTES + ufp_pkg::CHECK_BYTES};
    assign pos_plus_check = {1'b0, byte_count_reg} + {1'b0, ufp_pkg::CHECK_BYTES};

    always_comb
    begin
        phase_next          = phase_reg;
        sync_shift_next     = sync_shift_reg;
        byte_count_next     = byte_count_reg;
        expected_total_next = expected_total_reg;
        length_low_next     = length_low_reg;
        sum_a_next          = sum_a_reg;
        sum_b_next          = sum_b_reg;
        check_a_next        = check_a_reg;
        pos_next            = '0;
        event_next          = ufp_pkg::EV_HUNT;
        last_next           = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                pos_next        = byte_count_reg;
                byte_count_next = byte_count_reg + 16'd1;
                sum_a_next      = add_a;
                sum_b_next      = sum_b_reg + add_a;
                event_next      = ufp_pkg::EV_HEADER;
                if (byte_count_reg == 16'd2)
                begin
                    length_low_next = rx;
                end
                else if (byte_count_reg == ufp_pkg::HEADER_BYTES - 16'd1)
                begin
                    if (total > {1'b0, capacity_reg})
                    begin
                        event_next      = ufp_pkg::EV_TOO_LONG;
                        last_next       = 1'b1;
                        phase_next      = PH_HUNT;
                        sync_shift_next = '0;
                    end
                    else
                    begin
                        expected_total_next = total[15:0];
                        phase_next          = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                pos_next        = byte_count_reg;
                byte_count_next = byte_count_reg + 16'd1;
                if (pos_plus_check < {1'b0, expected_total_reg})
                begin
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    event_next = ufp_pkg::EV_PAYLOAD;
                end
                else if (pos_plus_check == {1'b0, expected_total_reg})
                begin
                    check_a_next = rx;
                    event_next   = ufp_pkg::EV_CHECK_A;
                end
                else
                begin
                    event_next      = (check_a_reg == sum_a_reg && rx == sum_b_reg)
                                    ? ufp_pkg::EV_GOOD : ufp_pkg::EV_BAD;
                    last_next       = 1'b1;
                    phase_next      = PH_HUNT;
                    sync_shift_next = '0;
                end
            end
            default:
            begin
                phase_next      = PH_HUNT;
                sync_shift_next = {sync_shift_reg[7:0], rx};
                if ({sync_shift_reg[7:0], rx} == ufp_pkg::SYNC_WORD)
                begin
                    event_next      = ufp_pkg::EV_SYNC;
                    phase_next      = PH_HEADER;
                    byte_count_next = '0;
                    sum_a_next      = '0;
                    sum_b_next      = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            capacity_reg       <= ufp_pkg::CAPACITY_RESET;
            sync_shift_reg     <= '0;
            byte_count_reg     <= '0;
            expected_total_reg <= '0;
            length_low_reg     <= '0;
            sum_a_reg          <= '0;
            sum_b_reg          <= '0;
            check_a_reg        <= '0;
            out_valid_reg      <= 1'b0;
            out_byte_reg       <= '0;
            out_pos_reg        <= '0;
            out_event_reg      <= ufp_pkg::EV_HUNT;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg          <= phase_next;
                sync_shift_reg     <= sync_shift_next;
                byte_count_reg     <= byte_count_next;
                expected_total_reg <= expected_total_next;
                length_low_reg     <= length_low_next;
                sum_a_reg          <= sum_a_next;
                sum_b_reg          <= sum_b_next;
                check_a_reg        <= check_a_next;
                out_byte_reg       <= rx;
                out_pos_reg        <= pos_next;
                out_event_reg      <= event_next;
                out_last_reg       <= last_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pos_reg, out_byte_reg};
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/core/ufp_checker.sv
// ----------------------------------------------------------------------------
// UBX frame parser checker
// Port-level assertions on the result stream of the UBX frame parser core.
// ----------------------------------------------------------------------------
module ufp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    // stalled transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser == ufp_pkg::EV_GOOD
            || m_axis_tuser == ufp_pkg::EV_BAD || m_axis_tuser == ufp_pkg::EV_TOO_LONG))
    else $error("tlast does not match end event");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ufp_pkg::EV_HUNT
            || m_axis_tuser == ufp_pkg::EV_SYNC) |-> m_axis_tdata[23:8] == 16'd0)
    else $error("nonzero position outside a frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ufp_pkg::EV_HEADER
            || m_axis_tuser == ufp_pkg::EV_TOO_LONG) |-> m_axis_tdata[23:8] < 16'd4)
    else $error("header position out of range");

endmodule

bind ubx_frame_parser_core ufp_checker u_ufp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/ubx_frame_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser core testbench
// Feeds directed and random byte streams (well-formed frames, bad checksums,
// oversize and truncated frames, noise) under random stalls on both streams,
// and checks every output tag against a cycle-free parser model or a pinned tag.
// ----------------------------------------------------------------------------
module ubx_frame_parser_core_tb;

    typedef enum logic [1:0] {SEEK, IN_HEADER, IN_BODY} parse_phase_t;

    typedef struct packed {
        logic [7:0]      data;
        logic [15:0]     pos;
        ufp_pkg::event_t ev;
        logic            fend;
    } byte_tag_t;

    typedef struct packed {
        logic      pinned;
        byte_tag_t tag;
    } pin_t;

    typedef struct packed {
        logic [7:0]      b;
        logic            pinned;
        logic [15:0]     pos;
        ufp_pkg::event_t ev;
        logic            fend;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;     // [7:0] data_out, [23:8] position
    logic [2:0]  m_axis_tuser;     // [2:0] event_res
    logic        m_axis_tlast;

    // parser model state
    parse_phase_t pst;
    logic [15:0]  sync_sr;
    logic [15:0]  cnt;
    logic [15:0]  total_len;
    logic [7:0]   len_lo;
    logic [7:0]   fl_a;
    logic [7:0]   fl_b;
    logic [7:0]   ck_a_rx;
    logic [15:0]  capacity;

    byte_tag_t pending_tags [$];
    pin_t      pinned_tags [$];
    int        mismatches;
    int        items_sent;
    logic      calm;

    dir_row_t    dir_rows [27];
    logic [15:0] caps [7];

    ubx_frame_parser_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic byte_tag_t parse_byte(input logic [7:0] b);
        byte_tag_t   t;
        logic [16:0] frame_len;
        t      = '{data: b, pos: 16'd0, ev: ufp_pkg::EV_HUNT, fend: 1'b0};
        case (pst)
            IN_HEADER:
            begin
                t.pos = cnt;
                cnt   = cnt + 16'd1;
                fl_a  = fl_a + b;
                fl_b  = fl_b + fl_a;
                t.ev  = ufp_pkg::EV_HEADER;
                if (t.pos == 16'd2)
                begin
                    len_lo = b;
                end
                else if (t.pos == ufp_pkg::HEADER_BYTES - 16'd1)
                begin
                    frame_len = {1'b0, b, len_lo}
                              + 17'(ufp_pkg::HEADER_BYTES + ufp_pkg::CHECK_BYTES);
                    if (frame_len > {1'b0, capacity})
                    begin
                        t.ev    = ufp_pkg::EV_TOO_LONG;
                        t.fend  = 1'b1;
                        pst     = SEEK;
                        sync_sr = 16'd0;
                    end
                    else
                    begin
                        total_len = frame_len[15:0];
                        pst       = IN_BODY;
                    end
                end
            end
            IN_BODY:
            begin
                t.pos = cnt;
                cnt   = cnt + 16'd1;
                if ({1'b0, t.pos} + 17'(ufp_pkg::CHECK_BYTES) < {1'b0, total_len})
                begin
                    fl_a = fl_a + b;
                    fl_b = fl_b + fl_a;
                    t.ev = ufp_pkg::EV_PAYLOAD;
                end
                else if ({1'b0, t.pos} + 17'(ufp_pkg::CHECK_BYTES) == {1'b0, total_len})
                begin
                    ck_a_rx = b;
                    t.ev    = ufp_pkg::EV_CHECK_A;
                end
                else
                begin
                    t.ev    = (ck_a_rx == fl_a && b == fl_b) ? ufp_pkg::EV_GOOD
                                                             : ufp_pkg::EV_BAD;
                    t.fend  = 1'b1;
                    pst     = SEEK;
                    sync_sr = 16'd0;
                end
            end
            default:
            begin
                pst     = SEEK;
                sync_sr = {sync_sr[7:0], b};
                if (sync_sr == ufp_pkg::SYNC_WORD)
                begin
                    t.ev = ufp_pkg::EV_SYNC;
                    pst  = IN_HEADER;
                    cnt  = 16'd0;
                    fl_a = 8'd0;
                    fl_b = 8'd0;
                end
            end
        endcase
        return t;
    endfunction

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge clk)
    begin
        byte_tag_t want;
        byte_tag_t got;
        byte_tag_t model;
        pin_t      pin;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{data: m_axis_tdata[7:0], pos: m_axis_tdata[23:8],
                        ev: ufp_pkg::event_t'(m_axis_tuser), fend: m_axis_tlast};
                if (pending_tags.size() == 0)
                begin
                    $display("%0t: unexpected transfer: data %h pos %0d event %0d last %b",
                             $time, got.data, got.pos, got.ev, got.fend);
                    mismatches++;
                end
                else
                begin
                    want = pending_tags.pop_front();
                    if (got.data != want.data || got.pos != want.pos ||
                        got.ev != want.ev || got.fend != want.fend)
                    begin
                        $display({"%0t: mismatch: expected data %h pos %0d event %0d ",
                                  "last %b, got data %h pos %0d event %0d last %b"},
                                 $time, want.data, want.pos, want.ev, want.fend,
                                 got.data, got.pos, got.ev, got.fend);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pin   = pinned_tags.pop_front();
                model = parse_byte(s_axis_tdata);
                pending_tags.push_back(pin.pinned ? pin.tag : model);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input pin_t pin);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        pinned_tags.push_back(pin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        items_sent++;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_tags.size() != 0 || pinned_tags.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity     = v;
    endtask

    // one frame attempt; fixed_len < 0 picks a random shape
    task automatic gen_frame(input int fixed_len);
        int         pick;
        int         len;
        int         cut;
        int         i;
        logic [7:0] hdr [4];
        logic [7:0] fa;
        logic [7:0] fb;
        logic [7:0] x;
        pick = $urandom_range(0, 99);
        if (fixed_len < 0 && pick < 12)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(($urandom_range(0, 3) == 0) ? ufp_pkg::SYNC_WORD[15:8]
                                                      : 8'($urandom), '0);
        end
        else
        begin
            len = fixed_len;
            if (len < 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(0, 12);
                else if (pick < 85)
                    len = $urandom_range(13, 40);
                else if (pick < 95 && capacity <= 16'd606)
                begin
                    // straddle the capacity limit
                    len = int'(capacity) - 7 + $urandom_range(0, 2);
                    if (len < 0)
                        len = 0;
                end
                else
                begin
                    len = ($urandom_range(0, 3) == 0) ? 65535 - $urandom_range(0, 6)
                                                      : $urandom_range(0, 65535);
                    if (len + 6 <= int'(capacity))
                        len = len % 41;
                end
            end
            hdr[0] = 8'($urandom);
            hdr[1] = 8'($urandom);
            hdr[2] = len[7:0];
            hdr[3] = len[15:8];
            send_byte(ufp_pkg::SYNC_WORD[15:8], '0);
            send_byte(ufp_pkg::SYNC_WORD[7:0], '0);
            fa = 8'd0;
            fb = 8'd0;
            for (i = 0; i < 4; i++)
            begin
                send_byte(hdr[i], '0);
                fa = fa + hdr[i];
                fb = fb + fa;
            end
            if (len + 6 <= int'(capacity))
            begin
                cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len) : -1;
                for (i = 0; i < len; i++)
                begin
                    if (i == cut)
                        break;
                    x = 8'($urandom);
                    send_byte(x, '0);
                    fa = fa + x;
                    fb = fb + fa;
                end
                if (cut < 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 12)
                        fa = fa ^ 8'($urandom_range(1, 255));
                    else if (pick < 24)
                        fb = fb ^ 8'($urandom_range(1, 255));
                    send_byte(fa, '0);
                    send_byte(fb, '0);
                end
            end
        end
    endtask

    initial
    begin
        pin_t p;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        calm          = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        pst           = SEEK;
        sync_sr       = 16'd0;
        cnt           = 16'd0;
        total_len     = 16'd0;
        len_lo        = 8'd0;
        fl_a          = 8'd0;
        fl_b          = 8'd0;
        ck_a_rx       = 8'd0;
        capacity      = ufp_pkg::CAPACITY_RESET;

        // byte, pinned, position, event, last
        dir_rows = '{
            '{8'h00, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hFF, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hB5, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h62, 1'b1, 16'd0, ufp_pkg::EV_SYNC,     1'b0},
            '{8'h01, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h07, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h02, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hAA, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h55, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h09, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hDA, 1'b1, 16'd7, ufp_pkg::EV_GOOD,     1'b1},
            '{8'hB5, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h62, 1'b1, 16'd0, ufp_pkg::EV_SYNC,     1'b0},
            '{8'h05, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h01, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},   // empty payload
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h00, 1'b1, 16'd5, ufp_pkg::EV_BAD,      1'b1},
            '{8'hB5, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h62, 1'b1, 16'd0, ufp_pkg::EV_SYNC,     1'b0},
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'h00, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hFF, 1'b0, 16'd0, ufp_pkg::EV_HUNT,     1'b0},
            '{8'hB5, 1'b1, 16'd3, ufp_pkg::EV_TOO_LONG, 1'b1},
            '{8'h62, 1'b1, 16'd0, ufp_pkg::EV_HUNT,     1'b0}    // shift cleared at abort
        };
        caps = '{16'd6, 16'd0, 16'hFFFF, 16'd5, 16'd7, 16'd512,
                 16'($urandom_range(6, 300))};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            p = {dir_rows[k].pinned, dir_rows[k].b, dir_rows[k].pos,
                 dir_rows[k].ev, dir_rows[k].fend};
            send_byte(dir_rows[k].b, p);
        end
        drain();

        foreach (caps[ph])
        begin
            write_capacity(caps[ph]);
            calm       = (ph == 2);
            items_sent = 0;
            if (calm)
                gen_frame(300);
            while (items_sent < 100)
                gen_frame(-1);
            // sometimes leave a frame open so the next write lands mid-frame
            if ($urandom_range(0, 1) == 1)
            begin
                send_byte(ufp_pkg::SYNC_WORD[15:8], '0);
                send_byte(ufp_pkg::SYNC_WORD[7:0], '0);
                send_byte(8'($urandom), '0);
                send_byte(8'($urandom), '0);
            end
            drain();
        end
        calm = 1'b0;

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ufp_pkg.sv
rtl/core/ubx_frame_parser_core.sv
rtl/core/ufp_checker.sv
verif/ubx_frame_parser_core_tb.sv
